// ----- rtl/core/pon_pkg.sv -----
// Package with the types and constants shared by the polygon orientation normalizer.
package pon_pkg;

	// Capacity of the vertex store and derived widths.
	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int AREA_W     = 40;

	// One stored vertex: x in the high half, y in the low half.
	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
	} vertex_t;

	localparam int VERTEX_W = $bits(vertex_t);

	// Input payload.
	typedef struct packed {
		logic signed [15:0] in_x;
		logic signed [15:0] in_y;
		logic               in_last;
	} in_item_t;

	// Output payload.
	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic               out_last;
		logic               out_reversed;
		logic               out_overflow;
	} out_item_t;

	// Control sequence states.
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CLOSE,
		ST_DRAIN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	// Request from the control logic to the area accumulator.
	typedef struct packed {
		logic    valid;
		logic    clear;
		vertex_t a;
		vertex_t b;
	} area_req_t;

endpackage

// ----- rtl/core/polygon_orientation_normalizer_core.sv -----
// Top level of the polygon orientation normalizer: vertex store, area and emit control.
// Vertices are accepted one per cycle while a polygon loads; each stored vertex is
// written to the vertex RAM and, after the first, its edge term enters a two-stage
// multiply-accumulate. After the vertex marked last is accepted, the closing edge is
// added and the control passes through close, pipeline drain and sign decision before
// the first read; then the n stored vertices stream out one per cycle, while the output
// is not stalled, through the RAM read register and an output register, in reverse
// order when the signed area is negative. No vertex is accepted during emission.
// Vertices beyond 64 are dropped and flagged on every output.
module polygon_orientation_normalizer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pon_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output pon_pkg::out_item_t  out_item
);
	import pon_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  issue_q;
	logic              ovf_q;
	logic              rev_q;
	vertex_t           first_q;
	vertex_t           prev_q;
	logic              rd_valid_s1;
	logic              rd_last_s1;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic              accept;
	logic              room;
	logic              store;
	logic              close_req;
	logic              decide;
	vertex_t           cur_v;
	area_req_t         area_req;
	logic signed [AREA_W-1:0] area_sum;
	logic              move;
	logic              re;
	logic [CNT_W-1:0]  raddr_full;
	logic [ADDR_W-1:0] raddr;
	logic [VERTEX_W-1:0] rdata;
	vertex_t           rd_v;
	logic              final_xfer;

	assign cur_v.vx = in_item.in_x;
	assign cur_v.vy = in_item.in_y;
	assign accept   = in_valid && in_ready;
	assign room     = count_q < CNT_W'(MAX_POINTS);
	assign store    = accept && room;
	assign move     = rd_valid_s1 && (!out_valid_q || out_ready);
	assign final_xfer = out_valid_q && out_ready && out_item_q.out_last;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and per-state controls.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		close_req = 1'b0;
		decide    = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid && in_item.in_last) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				close_req = 1'b1;
				state_d   = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				decide  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (final_xfer) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Polygon bookkeeping: count, overflow flag and direction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			rev_q   <= 1'b0;
		end else begin
			if (store) begin
				count_q <= count_q + CNT_W'(1);
			end else if (final_xfer) begin
				count_q <= '0;
			end
			if (accept && !room) begin
				ovf_q <= 1'b1;
			end else if (final_xfer) begin
				ovf_q <= 1'b0;
			end
			if (decide) begin
				rev_q <= area_sum < 0;
			end
		end
	end

	// First and previous vertex of the current polygon.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			prev_q  <= '0;
		end else if (store) begin
			prev_q <= cur_v;
			if (count_q == '0) begin
				first_q <= cur_v;
			end
		end
	end

	// Edge terms: each stored vertex after the first, then the closing edge.
	always_comb begin
		area_req.valid = (store && (count_q != '0)) || close_req;
		area_req.clear = final_xfer;
		area_req.a     = prev_q;
		area_req.b     = close_req ? first_q : cur_v;
	end

	pon_area u_area (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (area_req),
		.sum    (area_sum)
	);

	// Read issue: only during emission, so reads never meet the load-time writes.
	assign re         = (state_q == ST_EMIT) && (issue_q != count_q) && (!rd_valid_s1 || move);
	assign raddr_full = rev_q ? (count_q - CNT_W'(1) - issue_q) : issue_q;
	assign raddr      = raddr_full[ADDR_W-1:0];

	pon_ram #(
		.WIDTH (VERTEX_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (cur_v),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_v = rdata;

	// Issue counter and read stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			if (decide) begin
				issue_q <= '0;
			end else if (re) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (re) begin
				rd_valid_s1 <= 1'b1;
				rd_last_s1  <= issue_q == (count_q - CNT_W'(1));
			end else if (move) begin
				rd_valid_s1 <= 1'b0;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (move) begin
			out_item_q.out_x        <= rd_v.vx;
			out_item_q.out_y        <= rd_v.vy;
			out_item_q.out_last     <= rd_last_s1;
			out_item_q.out_reversed <= rev_q;
			out_item_q.out_overflow <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ----- rtl/core/pon_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module pon_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is enabled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/pon_area.sv -----
// Shoelace accumulator: two registered products, then a subtract and accumulate.
module pon_area (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pon_pkg::area_req_t               req,
	output logic signed [pon_pkg::AREA_W-1:0] sum
);
	import pon_pkg::*;

	logic               valid_s1;
	logic signed [31:0] p1_s1;
	logic signed [31:0] p2_s1;
	logic signed [AREA_W-1:0] sum_q;

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	// Stage one products of the cross term a.x*b.y - a.y*b.x.
	always_ff @(posedge clk) begin
		if (req.valid) begin
			p1_s1 <= 32'(req.a.vx) * 32'(req.b.vy);
			p2_s1 <= 32'(req.a.vy) * 32'(req.b.vx);
		end
	end

	// Stage two accumulation; clear is only requested with the pipeline empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (req.clear) begin
			sum_q <= '0;
		end else if (valid_s1) begin
			sum_q <= sum_q + AREA_W'(p1_s1) - AREA_W'(p2_s1);
		end
	end

	assign sum = sum_q;

endmodule

// ----- rtl/core/pon_checker.sv -----
// Port-level checker for the polygon orientation normalizer, with its bind.
module pon_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input pon_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input pon_pkg::out_item_t out_item
);
	import pon_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("output changed while stalled");

	// Loading and emission never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is shown");

	// A transfer of the last vertex closes the input side.
	a_last_in_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.in_last) |=> !in_ready)
		else $error("input still ready after last vertex");

	// The final result reopens the input side.
	a_last_out_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_item.out_last) |=> in_ready)
		else $error("input not ready after final result");

endmodule

bind polygon_orientation_normalizer_core pon_checker u_pon_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

// ----- tb/tb_polygon_orientation_normalizer_core.sv -----
// Testbench for the polygon orientation normalizer: polygon stimulus, ordering predictor and checker.
`timescale 1ns / 1ps

module tb_polygon_orientation_normalizer_core;
	import pon_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
	typedef enum int {SHAPE_WIDE, SHAPE_NEAR, SHAPE_EDGE, SHAPE_LINE} shape_e;

	localparam int PHASE_VERTICES = 36;
	localparam int SETTLE_CYCLES  = 2 * MAX_POINTS + 20;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	polygon_orientation_normalizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #2 clk = ~clk;

	// Vertices waiting to be driven and results expected in normalized order.
	in_item_t   vertex_feed[$];
	out_item_t  ordered_vertices_due[$];
	int         vertices_fed = 0;
	int         vertices_accepted = 0;
	int         fault_count = 0;
	bit         vertex_taken = 1'b0;
	idle_mode_e idle_mode = IDLE_NONE;

	// Predictor state: the polygon being collected and its running shoelace sum.
	vertex_t                     held[MAX_POINTS];
	int                          held_count = 0;
	logic signed [AREA_W-1:0]    area_acc = '0;
	vertex_t                     first_v = '0;
	vertex_t                     prev_v = '0;
	bit                          dropped = 1'b0;

	function automatic longint edge_cross(vertex_t a, vertex_t b);
		return longint'($signed(a.vx)) * longint'($signed(b.vy))
			- longint'($signed(a.vy)) * longint'($signed(b.vx));
	endfunction

	// Add an accepted vertex; on the last, queue the polygon, reversed if its area is negative.
	task automatic absorb_vertex(in_item_t it);
		vertex_t   v;
		out_item_t r;
		int        n;
		bit        rev;
		v.vx = it.in_x;
		v.vy = it.in_y;
		if (held_count < MAX_POINTS) begin
			held[held_count] = v;
			if (held_count == 0)
				first_v = v;
			else
				area_acc += edge_cross(prev_v, v);
			prev_v = v;
			held_count++;
		end else begin
			dropped = 1'b1;
		end
		if (it.in_last) begin
			if (held_count > 0)
				area_acc += edge_cross(prev_v, first_v);
			n = held_count;
			rev = (area_acc < 0);
			for (int k = 0; k < n; k++) begin
				r.out_x        = held[rev ? (n - 1 - k) : k].vx;
				r.out_y        = held[rev ? (n - 1 - k) : k].vy;
				r.out_last     = (k == n - 1);
				r.out_reversed = rev;
				r.out_overflow = dropped;
				ordered_vertices_due.push_back(r);
			end
			held_count = 0;
			area_acc = '0;
			dropped = 1'b0;
		end
	endtask

	function automatic bit sender_idles();
		if (idle_mode == IDLE_SENDER)
			return $urandom_range(0, 99) < 71;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(0, 99) < 37;
		return 1'b0;
	endfunction

	function automatic bit receiver_stalls();
		if (idle_mode == IDLE_RECEIVER)
			return $urandom_range(0, 99) < 71;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(0, 99) < 37;
		return 1'b0;
	endfunction

	// Driver: inputs change on the falling edge; a presented vertex holds until its transfer.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || vertex_taken) begin
				if (vertex_feed.size() > 0 && !sender_idles()) begin
					in_item  <= vertex_feed.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			vertex_taken = 1'b0;
			out_ready <= !receiver_stalls();
		end
	end

	// Monitor: sample both channels on the rising edge.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				absorb_vertex(in_item);
				vertices_accepted++;
				vertex_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (ordered_vertices_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected transfer: x=%0d y=%0d last=%b rev=%b ovf=%b",
							out_item.out_x, out_item.out_y, out_item.out_last,
							out_item.out_reversed, out_item.out_overflow);
				end else begin
					want = ordered_vertices_due.pop_front();
					if (want.out_x !== out_item.out_x || want.out_y !== out_item.out_y
						|| want.out_last !== out_item.out_last
						|| want.out_reversed !== out_item.out_reversed
						|| want.out_overflow !== out_item.out_overflow) begin
						fault_count++;
						if (fault_count <= 10)
							$display("wrong vertex: want x=%0d y=%0d last=%b rev=%b ovf=%b, got x=%0d y=%0d last=%b rev=%b ovf=%b",
								want.out_x, want.out_y, want.out_last, want.out_reversed,
								want.out_overflow, out_item.out_x, out_item.out_y,
								out_item.out_last, out_item.out_reversed, out_item.out_overflow);
					end
				end
			end
		end
	end

	task automatic add_vertex(int x, int y, bit last);
		in_item_t it;
		it.in_x    = x[15:0];
		it.in_y    = y[15:0];
		it.in_last = last;
		vertex_feed.push_back(it);
		vertices_fed++;
	endtask

	function automatic int pick_coord(shape_e shape);
		case (shape)
			SHAPE_NEAR: return int'($urandom_range(0, 16)) - 8;
			SHAPE_EDGE: begin
				case ($urandom_range(0, 3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// Queue one polygon of n vertices; collinear shapes give a zero area.
	task automatic queue_polygon(int n, shape_e shape);
		int bx, by, dx, dy, t;
		bx = int'($urandom_range(0, 2000)) - 1000;
		by = int'($urandom_range(0, 2000)) - 1000;
		dx = int'($urandom_range(0, 100)) - 50;
		dy = int'($urandom_range(0, 100)) - 50;
		for (int i = 0; i < n; i++) begin
			if (shape == SHAPE_LINE) begin
				t = int'($urandom_range(0, 40)) - 20;
				add_vertex(bx + t * dx, by + t * dy, i == n - 1);
			end else begin
				add_vertex(pick_coord(shape), pick_coord(shape), i == n - 1);
			end
		end
	endtask

	task automatic wait_drained();
		while (vertices_accepted != vertices_fed || ordered_vertices_due.size() != 0)
			@(negedge clk);
	endtask

	// Stimulus: directed polygons, then random polygons in four idling phases.
	initial begin
		int     start_count;
		int     n;
		int     r;
		shape_e shape;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single vertex and two vertices keep their order.
		add_vertex(32767, -32768, 1'b1);
		add_vertex(-32768, 32767, 1'b0);
		add_vertex(0, 0, 1'b1);
		// Full-range triangle, counterclockwise; its doubled area exceeds the signed 32-bit range.
		add_vertex(-32768, -32768, 1'b0);
		add_vertex(32767, -32768, 1'b0);
		add_vertex(32767, 32767, 1'b1);
		// The same triangle clockwise is reversed.
		add_vertex(-32768, -32768, 1'b0);
		add_vertex(32767, 32767, 1'b0);
		add_vertex(32767, -32768, 1'b1);
		// Collinear points give a zero area and keep their order.
		add_vertex(1, 1, 1'b0);
		add_vertex(2, 2, 1'b0);
		add_vertex(3, 3, 1'b1);
		// Clockwise unit square.
		add_vertex(0, 0, 1'b0);
		add_vertex(0, 1, 1'b0);
		add_vertex(1, 1, 1'b0);
		add_vertex(1, 0, 1'b1);
		// Small triangle on all-ones coordinates.
		add_vertex(-1, -1, 1'b0);
		add_vertex(0, -1, 1'b0);
		add_vertex(-1, 0, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			idle_mode = idle_mode_e'(ph);
			start_count = vertices_fed;
			// Overflow with a dropped last vertex, and a store filled exactly.
			if (ph == 1)
				queue_polygon(MAX_POINTS + 2, SHAPE_WIDE);
			if (ph == 3)
				queue_polygon(MAX_POINTS, SHAPE_NEAR);
			while (vertices_fed - start_count < PHASE_VERTICES) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					n = $urandom_range(1, 2);
				else if (r <= 2)
					n = $urandom_range(13, 24);
				else
					n = $urandom_range(3, 12);
				r = $urandom_range(0, 9);
				if (r < 5)
					shape = SHAPE_WIDE;
				else if (r < 7 || r == 9)
					shape = SHAPE_NEAR;
				else if (r == 7)
					shape = SHAPE_EDGE;
				else
					shape = SHAPE_LINE;
				queue_polygon(n, shape);
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (ordered_vertices_due.size() != 0)
			fault_count++;
		if (fault_count == 0)
			$display("polygon_orientation_normalizer_core: match");
		else
			$display("polygon_orientation_normalizer_core: mismatch");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("polygon_orientation_normalizer_core: mismatch");
		$finish;
	end

endmodule
